// ----- rtl/cqfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cqfa_pkg
// Shared types and constants for the context queue and frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cqfa_pkg;

    localparam int MAX_CONTEXTS    = 16;
    localparam int PAGES_PER_SPACE = 1024;
    localparam int FRAME_BYTES     = 4096;

    localparam int ID_W        = 8;
    localparam int PAGE_W      = 10;
    localparam int ADDR_W      = 32;
    localparam int POOL_W      = 21;
    localparam int QIDX_W      = $clog2(MAX_CONTEXTS);
    localparam int QCNT_W      = $clog2(MAX_CONTEXTS + 1);
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int CFG_IDX_W   = 1;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 56;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_SWITCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_MAP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OUT_CREATED   = 3'd0,
        OUT_SWITCHED  = 3'd1,
        OUT_IDLE      = 3'd2,
        OUT_DELETED   = 3'd3,
        OUT_MAPPED    = 3'd4,
        OUT_NOT_FOUND = 3'd5,
        OUT_NO_FRAMES = 3'd6
    } outcome_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 1'd1;

endpackage

`default_nettype wire

// ----- rtl/cqfa_id_ram.sv -----
// ----------------------------------------------------------------------------
// cqfa_id_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cqfa_id_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/context_queue_and_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// context_queue_and_frame_allocator_core
// Context scheduler with an ordered ready queue and a sequential frame pool.
// ----------------------------------------------------------------------------
// One command is taken at a time and answered by exactly one result transfer.
// The ready queue lives in a single-port-read RAM and is walked by one
// compare/index unit, so a command's run time depends on the queue contents:
// create goes from execute straight to the response step; switch reads the
// queue head and moves every other queued id down one place; delete and map
// go straight to the response step when the id is current, else scan the
// queue entry by entry. A map that finds the id stops its scan there, and a
// delete from the queue also moves the entries behind the removed one down.
// The next command is taken once the previous one has been handed to the
// output register; the response step waits while that register stays full.
// Frames are handed out as frame_base + k * 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module context_queue_and_frame_allocator_core
    import cqfa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // slave side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // context_id, page_index, zero pad
    input  wire logic [1:0]            s_tuser,   // operation
    // master side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // result_id, mapped_page, frame_address, pad
    output logic      [2:0]            m_tuser,   // outcome
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [ADDR_W-1:0]     cfg_wdata
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_EXEC  = 8'b0000_0010,
        ST_HEAD  = 8'b0000_0100,
        ST_SCAN  = 8'b0000_1000,
        ST_CHECK = 8'b0001_0000,
        ST_SHRD  = 8'b0010_0000,
        ST_SHWR  = 8'b0100_0000,
        ST_RESP  = 8'b1000_0000
    } state_t;

    localparam logic [PAGE_W:0]   PAGE_LIMIT = (PAGE_W + 1)'(PAGES_PER_SPACE);
    localparam logic [QCNT_W-1:0] QFULL      = QCNT_W'(MAX_CONTEXTS);

    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [QCNT_W-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0]     nxt_id_reg, nxt_id_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [ID_W-1:0]     cur_id_reg, cur_id_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [POOL_W-1:0]   given_reg, given_next;
    logic [ADDR_W-1:0]   base_reg;
    logic [POOL_W-1:0]   pool_reg;

    outcome_t            res_outcome_reg, res_outcome_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [PAGE_W-1:0]   res_page_reg, res_page_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;

    logic                m_tvalid_reg, m_tvalid_next;
    outcome_t            m_outcome_reg;
    logic [ID_W-1:0]     m_id_reg;
    logic [PAGE_W-1:0]   m_page_reg;
    logic [ADDR_W-1:0]   m_addr_reg;

    logic                ram_we;
    logic [QIDX_W-1:0]   ram_waddr;
    logic [ID_W-1:0]     ram_wdata;
    logic [QIDX_W-1:0]   ram_raddr;
    logic [ID_W-1:0]     ram_rdata;

    logic                s_accept;
    logic                out_load;
    logic                cur_hit;
    logic                page_ok;
    logic                alloc_ok;
    logic [ADDR_W-1:0]   frame_addr;
    outcome_t            alloc_outcome;
    logic [PAGE_W-1:0]   alloc_page;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [POOL_W-1:0]   alloc_given;
    logic [QCNT_W-1:0]   idx_inc;
    logic [QCNT_W-1:0]   count_dec;

    cqfa_id_ram #(
        .DEPTH (MAX_CONTEXTS),
        .WIDTH (ID_W)
    ) u_ready_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_RESP) && (!m_tvalid_reg || m_tready);

    assign cur_hit   = cur_valid_reg && (cur_id_reg == id_reg);
    assign page_ok   = {1'b0, page_reg} < PAGE_LIMIT;
    assign alloc_ok  = given_reg < pool_reg;
    assign frame_addr = base_reg + (ADDR_W'(given_reg) << FRAME_SHIFT);
    assign alloc_outcome = alloc_ok ? OUT_MAPPED : OUT_NO_FRAMES;
    assign alloc_page    = alloc_ok ? page_reg : '0;
    assign alloc_addr    = alloc_ok ? frame_addr : '0;
    assign alloc_given   = alloc_ok ? given_reg + POOL_W'(1) : given_reg;
    assign idx_inc   = idx_reg + QCNT_W'(1);
    assign count_dec = count_reg - QCNT_W'(1);

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        nxt_id_next      = nxt_id_reg;
        count_next       = count_reg;
        cur_id_next      = cur_id_reg;
        cur_valid_next   = cur_valid_reg;
        given_next       = given_reg;
        res_outcome_next = res_outcome_reg;
        res_id_next      = res_id_reg;
        res_page_next    = res_page_reg;
        res_addr_next    = res_addr_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_outcome_next = OUT_NOT_FOUND;
                res_id_next      = id_reg;
                res_page_next    = '0;
                res_addr_next    = '0;
                unique case (op_reg)
                    OP_CREATE: begin
                        if (cur_valid_reg && count_reg < QFULL) begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[QIDX_W-1:0];
                            ram_wdata  = cur_id_reg;
                            count_next = count_reg + QCNT_W'(1);
                        end
                        cur_id_next      = id_reg;
                        cur_valid_next   = 1'b1;
                        res_outcome_next = OUT_CREATED;
                        state_next       = ST_RESP;
                    end
                    OP_SWITCH: begin
                        if (count_reg != '0) begin
                            ram_raddr  = '0;
                            state_next = ST_HEAD;
                        end else begin
                            if (cur_valid_reg) begin
                                res_outcome_next = OUT_SWITCHED;
                                res_id_next      = cur_id_reg;
                            end else begin
                                res_outcome_next = OUT_IDLE;
                                res_id_next      = '0;
                            end
                            state_next = ST_RESP;
                        end
                    end
                    OP_DELETE: begin
                        if (cur_hit) begin
                            cur_valid_next   = 1'b0;
                            res_outcome_next = OUT_DELETED;
                            state_next       = ST_RESP;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    OP_MAP: begin
                        if (!page_ok) begin
                            state_next = ST_RESP;
                        end else if (cur_hit) begin
                            res_outcome_next = alloc_outcome;
                            res_page_next    = alloc_page;
                            res_addr_next    = alloc_addr;
                            given_next       = alloc_given;
                            state_next       = ST_RESP;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_HEAD: begin
                nxt_id_next = ram_rdata;
                idx_next    = '0;
                state_next  = ST_SHRD;
            end
            ST_SCAN: begin
                if (idx_reg == count_reg) begin
                    state_next = ST_RESP;
                end else begin
                    ram_raddr  = idx_reg[QIDX_W-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (ram_rdata == id_reg) begin
                    if (op_reg == OP_DELETE) begin
                        state_next = ST_SHRD;
                    end else begin
                        res_outcome_next = alloc_outcome;
                        res_page_next    = alloc_page;
                        res_addr_next    = alloc_addr;
                        given_next       = alloc_given;
                        state_next       = ST_RESP;
                    end
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_SCAN;
                end
            end
            ST_SHRD: begin
                if (idx_inc < count_reg) begin
                    ram_raddr  = idx_inc[QIDX_W-1:0];
                    state_next = ST_SHWR;
                end else begin
                    if (op_reg == OP_SWITCH) begin
                        if (cur_valid_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = count_dec[QIDX_W-1:0];
                            ram_wdata = cur_id_reg;
                        end else begin
                            count_next = count_dec;
                        end
                        cur_id_next      = nxt_id_reg;
                        cur_valid_next   = 1'b1;
                        res_outcome_next = OUT_SWITCHED;
                        res_id_next      = nxt_id_reg;
                    end else begin
                        count_next       = count_dec;
                        res_outcome_next = OUT_DELETED;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_SHWR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[QIDX_W-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = ST_SHRD;
            end
            ST_RESP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cur_id_reg    <= '0;
            cur_valid_reg <= 1'b0;
            given_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            base_reg      <= '0;
            pool_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_id_reg    <= cur_id_next;
            cur_valid_reg <= cur_valid_next;
            given_reg     <= given_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_FRAME_BASE: base_reg <= cfg_wdata;
                    CFG_POOL_COUNT: pool_reg <= cfg_wdata[POOL_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= op_t'(s_tuser);
            id_reg   <= s_tdata[ID_W-1:0];
            page_reg <= s_tdata[ID_W +: PAGE_W];
        end
        idx_reg         <= idx_next;
        nxt_id_reg      <= nxt_id_next;
        res_outcome_reg <= res_outcome_next;
        res_id_reg      <= res_id_next;
        res_page_reg    <= res_page_next;
        res_addr_reg    <= res_addr_next;
        if (out_load) begin
            m_outcome_reg <= res_outcome_reg;
            m_id_reg      <= res_id_reg;
            m_page_reg    <= res_page_reg;
            m_addr_reg    <= res_addr_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_outcome_reg;
    assign m_tdata  = {{(M_DATA_W - ID_W - PAGE_W - ADDR_W){1'b0}},
                       m_addr_reg, m_page_reg, m_id_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QFULL)
        else $error("ready queue count exceeds capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_EXEC))
        else $error("accepted command did not start execution");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result transfer raised outside the response step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_SHRD) |-> (idx_reg <= count_reg))
        else $error("queue index ran past the fill count");

endmodule

`default_nettype wire
